@@ design/cgl_pkg.sv @@
// Shared types, constants and helper functions of the color grading texel pipeline.
// No dependencies; every other design file references this package by scoped names.
package cgl_pkg;

  localparam int LATTICE_SIZE_DEF = 32;
  localparam int IDX_W     = 6;
  localparam int IDX_N     = 2 ** IDX_W;
  localparam int COORD_W   = 17;
  localparam int Q16_ONE   = 65536;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;
  localparam int Q12_W     = 16;
  localparam int HALF_W    = 16;
  localparam int V_W       = 20;   // linear value, Q16
  localparam int MANT_W    = 31;   // normalized mantissa and exp2 accumulator, Q30
  localparam int POW_W     = 31;   // graded channel, Q16, capped at 0x7FFFFFFF
  localparam int LOG_STEPS = 16;
  localparam int EXP_STEPS = 16;
  localparam int NUM_W     = 33;   // divider numerator (|log2| * 4096 + gamma / 2)
  localparam int DEN_W     = 15;   // floored gamma
  localparam int QUO_W     = 31;
  localparam int GAMMA_FLOOR = 4;

  localparam logic [CFG_IDX_W-1:0] REG_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CON   = 3'd4;

  localparam logic [CFG_W-1:0] PARAMS_RST = 48'h1000_0000_1000;
  localparam logic [Q12_W-1:0] Q12_ONE    = 16'h1000;

  localparam logic [15:0] LUMA_WR = 16'd13933;
  localparam logic [15:0] LUMA_WG = 16'd46871;
  localparam logic [15:0] LUMA_WB = 16'd4732;

  localparam int CH_LAT   = 4 + LOG_STEPS + 1 + NUM_W + 1 + EXP_STEPS + 1;
  localparam int MIX_LAT  = 7;
  localparam int PIPE_LAT = CH_LAT + MIX_LAT;

  typedef struct packed {
    logic [15:0] gain;
    logic [15:0] lift;
    logic [15:0] gamma;
  } ch_params_t;

  typedef struct packed {
    logic       zero;
    logic [4:0] msb;
  } log_side_t;

  typedef struct packed {
    logic zero;
    logic neg;
  } div_side_t;

  typedef struct packed {
    logic        zero;
    logic        cap;
    logic [15:0] n;
  } exp_side_t;

  // integer square root, elaboration use only
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bt;
    x   = x_in;
    res = '0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bt > x) bt = bt >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != 0) begin
        if (x >= res + bt) begin
          x   = x - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // 2^(2^-k) in Q30, built by repeated square roots
  function automatic logic [63:0] exp_root(input int k);
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int j = 1; j <= k; j++) begin
      r = isqrt64(r << 30);
    end
    return r;
  endfunction

  // x / 4096 rounded half away from zero
  function automatic logic signed [63:0] shr_round12(input logic signed [63:0] x);
    logic [63:0] mag;
    mag = (x < 0) ? 64'(-x) : 64'(x);
    mag = (mag + 64'd2048) >> 12;
    return (x < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  // Q16 in [0,1] to half, round to nearest even, tiny values flushed to zero
  function automatic logic [HALF_W-1:0] to_half(input logic [COORD_W-1:0] u);
    logic [4:0]         p;
    logic [4:0]         ex;
    logic [4:0]         s;
    logic [11:0]        m;
    logic [COORD_W-1:0] rem;
    logic [COORD_W-1:0] half;
    logic [COORD_W-1:0] shl;
    logic [HALF_W-1:0]  res;
    p = '0;
    for (int i = 0; i < COORD_W; i++) begin
      if (u[i]) p = 5'(i);
    end
    ex  = p - 5'd1;
    shl = '0;
    m   = '0;
    if (p < 5'd2) begin
      res = '0;
    end else if (p <= 5'd10) begin
      shl = u << (5'd10 - p);
      res = {1'b0, ex, shl[9:0]};
    end else begin
      s    = p - 5'd10;
      m    = 12'(u >> s);
      rem  = u & ((17'd1 << s) - 17'd1);
      half = 17'd1 << (s - 5'd1);
      if (rem > half || (rem == half && m[0])) m = m + 12'd1;
      if (m[11]) begin
        m  = m >> 1;
        ex = ex + 5'd1;
      end
      res = {1'b0, ex, m[9:0]};
    end
    return res;
  endfunction

endpackage

@@ design/color_grade_lut_texel_top.sv @@
// Color grading lattice texel generator: lattice point in, three graded half floats out.
// Depends on cgl_pkg, cgl_channel and cgl_mix.
//
// Usage:
//   s_axis carries one lattice point per word (red, green, blue index); m_axis
//   returns the graded red, green and blue half-float patterns of that point.
//   Words come out in input order, one result per input word.
//   Throughput: one word per clock unless the receiver stalls. An accepted word
//   reaches m_axis_tvalid through the per-channel pipeline (log2 squaring stages,
//   one-bit-per-stage gamma divider, exp2 root multiplies), then through the
//   luma/saturation/contrast/half stages and the output register.
//   Grading registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
//   must write them only while the pipeline is empty, which the block does not
//   enforce itself; writes to unused indexes are dropped. Reset clears all valid
//   bits and loads unity gain/gamma, zero lift and unity saturation and contrast.
//   When the receiver stalls, the output register holds its word; the pipeline
//   keeps moving to fill its bubbles and freezes only when its last stage holds a
//   word that cannot move on, which then also drops s_axis_tready.
module color_grade_lut_texel_top #(
  parameter int LATTICE_SIZE = cgl_pkg::LATTICE_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // red_index, green_index, blue_index
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [47:0]                    m_axis_tdata,  // red_half, green_half, blue_half
  input  logic                           cfg_we_i,
  input  logic [cgl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cgl_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int IW = cgl_pkg::IDX_W;
  localparam int HW = cgl_pkg::HALF_W;
  localparam int L  = cgl_pkg::PIPE_LAT;

  cgl_pkg::ch_params_t          params_q [3];
  logic [cgl_pkg::Q12_W-1:0]    sat_q, con_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      params_q[0] <= cgl_pkg::PARAMS_RST;
      params_q[1] <= cgl_pkg::PARAMS_RST;
      params_q[2] <= cgl_pkg::PARAMS_RST;
      sat_q       <= cgl_pkg::Q12_ONE;
      con_q       <= cgl_pkg::Q12_ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cgl_pkg::REG_RED:   params_q[0] <= cfg_data_i;
        cgl_pkg::REG_GREEN: params_q[1] <= cfg_data_i;
        cgl_pkg::REG_BLUE:  params_q[2] <= cfg_data_i;
        cgl_pkg::REG_SAT:   sat_q       <= cfg_data_i[cgl_pkg::Q12_W-1:0];
        cgl_pkg::REG_CON:   con_q       <= cfg_data_i[cgl_pkg::Q12_W-1:0];
        default: ;
      endcase
    end
  end

  logic [L-1:0]  vld_q;
  logic          out_vld_q;
  logic [47:0]   out_data_q;
  logic          en;

  // advance unless the last stage holds a word the output register cannot take
  assign en            = !vld_q[L-1] || !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  logic [cgl_pkg::POW_W-1:0]  pow  [3];
  logic [HW-1:0]              half [3];

  for (genvar gi = 0; gi < 3; gi++) begin : g_ch
    cgl_channel #(
      .LATTICE_SIZE (LATTICE_SIZE)
    ) u_channel (
      .clk_i    (clk_i),
      .en_i     (en),
      .idx_i    (s_axis_tdata[gi*IW +: IW]),
      .params_i (params_q[gi]),
      .pow_o    (pow[gi])
    );
  end

  cgl_mix u_mix (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (pow),
    .sat_i  (sat_q),
    .con_i  (con_q),
    .half_o (half)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[L-2:0], s_axis_tvalid};
      end
      if (en && vld_q[L-1]) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[L-1]) begin
      out_data_q <= {half[2], half[1], half[0]};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ design/cgl_log2.sv @@
// Pipelined fractional log2: one squaring of the Q30 mantissa per stage.
// Depends on cgl_pkg.
module cgl_log2 (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [cgl_pkg::MANT_W-1:0] m_i,
  input  cgl_pkg::log_side_t       side_i,
  output logic [15:0]              f_o,
  output cgl_pkg::log_side_t       side_o
);

  localparam int N = cgl_pkg::LOG_STEPS;

  logic [cgl_pkg::MANT_W-1:0] m_q    [N];
  logic [15:0]                f_q    [N];
  cgl_pkg::log_side_t         side_q [N];

  for (genvar gi = 0; gi < N; gi++) begin : g_step
    logic [cgl_pkg::MANT_W-1:0] m_in;
    logic [15:0]                f_in;
    cgl_pkg::log_side_t         s_in;
    logic [2*cgl_pkg::MANT_W-1:0] sq;
    logic [31:0]                t;

    if (gi == 0) begin : g_first
      assign m_in = m_i;
      assign f_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign m_in = m_q[gi-1];
      assign f_in = f_q[gi-1];
      assign s_in = side_q[gi-1];
    end

    assign sq = m_in * m_in;
    assign t  = sq[61:30];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[gi]    <= t[31] ? t[31:1] : t[30:0];
        f_q[gi]    <= {f_in[14:0], t[31]};
        side_q[gi] <= s_in;
      end
    end
  end

  assign f_o    = f_q[N-1];
  assign side_o = side_q[N-1];

endmodule

@@ design/cgl_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, static divisor.
// Depends on cgl_pkg.
module cgl_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [cgl_pkg::NUM_W-1:0] num_i,
  input  logic [cgl_pkg::DEN_W-1:0] den_i,
  input  cgl_pkg::div_side_t        side_i,
  output logic [cgl_pkg::NUM_W-1:0] quo_o,
  output cgl_pkg::div_side_t        side_o
);

  localparam int N  = cgl_pkg::NUM_W;
  localparam int DW = cgl_pkg::DEN_W;

  // nq shifts numerator bits out at the top and quotient bits in at the bottom
  logic [N-1:0]        nq_q   [N];
  logic [DW-1:0]       rem_q  [N];
  cgl_pkg::div_side_t  side_q [N];

  for (genvar gi = 0; gi < N; gi++) begin : g_step
    logic [N-1:0]       nq_in;
    logic [DW-1:0]      rem_in;
    cgl_pkg::div_side_t s_in;
    logic [DW:0]        t;
    logic [DW:0]        diff;
    logic               ge;

    if (gi == 0) begin : g_first
      assign nq_in  = num_i;
      assign rem_in = '0;
      assign s_in   = side_i;
    end else begin : g_next
      assign nq_in  = nq_q[gi-1];
      assign rem_in = rem_q[gi-1];
      assign s_in   = side_q[gi-1];
    end

    assign t    = {rem_in, nq_in[N-1]};
    assign ge   = t >= {1'b0, den_i};
    assign diff = t - {1'b0, den_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[gi]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        nq_q[gi]   <= {nq_in[N-2:0], ge};
        side_q[gi] <= s_in;
      end
    end
  end

  assign quo_o  = nq_q[N-1];
  assign side_o = side_q[N-1];

endmodule

@@ design/cgl_exp2.sv @@
// Pipelined fractional exp2: one conditional multiply by a constant root per stage.
// Depends on cgl_pkg (root table function).
module cgl_exp2 (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [15:0]                 f_i,
  input  cgl_pkg::exp_side_t          side_i,
  output logic [cgl_pkg::MANT_W-1:0]  acc_o,
  output cgl_pkg::exp_side_t          side_o
);

  localparam int N  = cgl_pkg::EXP_STEPS;
  localparam int MW = cgl_pkg::MANT_W;

  logic [MW-1:0]      acc_q  [N];
  logic [15:0]        f_q    [N];
  cgl_pkg::exp_side_t side_q [N];

  for (genvar gi = 0; gi < N; gi++) begin : g_step
    localparam logic [MW-1:0] Root = MW'(cgl_pkg::exp_root(gi + 1));
    logic [MW-1:0]      acc_in;
    logic [15:0]        f_in;
    cgl_pkg::exp_side_t s_in;
    logic [2*MW-1:0]    prod;

    if (gi == 0) begin : g_first
      assign acc_in = MW'(1) << 30;
      assign f_in   = f_i;
      assign s_in   = side_i;
    end else begin : g_next
      assign acc_in = acc_q[gi-1];
      assign f_in   = f_q[gi-1];
      assign s_in   = side_q[gi-1];
    end

    assign prod = acc_in * Root;

    // fraction bits taken from the top down
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[gi]  <= f_in[15-gi] ? prod[60:30] : acc_in;
        f_q[gi]    <= f_in;
        side_q[gi] <= s_in;
      end
    end
  end

  assign acc_o  = acc_q[N-1];
  assign side_o = side_q[N-1];

endmodule

@@ design/cgl_channel.sv @@
// One color channel: lattice coordinate, gain/lift, and pow as exp2(log2 / gamma).
// Depends on cgl_pkg, cgl_log2, cgl_div and cgl_exp2.
module cgl_channel #(
  parameter int LATTICE_SIZE = cgl_pkg::LATTICE_SIZE_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [cgl_pkg::IDX_W-1:0]  idx_i,
  input  cgl_pkg::ch_params_t        params_i,
  output logic [cgl_pkg::POW_W-1:0]  pow_o
);

  localparam int Den = LATTICE_SIZE - 1;
  localparam int CW  = cgl_pkg::COORD_W;
  localparam int MW  = cgl_pkg::MANT_W;

  // coordinate per index, out-of-range indexes saturated
  logic [CW-1:0] coord_tab [cgl_pkg::IDX_N];
  for (genvar gi = 0; gi < cgl_pkg::IDX_N; gi++) begin : g_tab
    localparam int Idx   = (gi > Den) ? Den : gi;
    localparam int Coord = (Idx * cgl_pkg::Q16_ONE + Den / 2) / Den;
    assign coord_tab[gi] = CW'(Coord);
  end

  logic [CW-1:0]            c_q;
  logic signed [33:0]       pg_q, pl_q;
  logic [cgl_pkg::V_W-1:0]  v_q;
  logic [MW-1:0]            m_q;
  cgl_pkg::log_side_t       lside_q;

  logic signed [34:0]       v28;
  logic [34:0]              v_rnd;
  logic [4:0]               msb;
  logic [CW-1:0]            one_m_c;

  assign one_m_c = CW'(cgl_pkg::Q16_ONE) - c_q;
  assign v28     = 35'(pg_q) + 35'(pl_q);
  assign v_rnd   = 35'(v28) + 35'd2048;

  always_comb begin
    msb = '0;
    for (int i = 0; i < cgl_pkg::V_W; i++) begin
      if (v_q[i]) msb = 5'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q  <= coord_tab[idx_i];
      pg_q <= $signed(params_i.gain) * $signed({1'b0, c_q});
      pl_q <= $signed(params_i.lift) * $signed({1'b0, one_m_c});
      v_q  <= (v28 <= 0) ? '0 : v_rnd[31:12];
      m_q          <= MW'(v_q) << (5'd30 - msb);
      lside_q.msb  <= msb;
      lside_q.zero <= (v_q == '0);
    end
  end

  logic [15:0]        lf;
  cgl_pkg::log_side_t lside;

  cgl_log2 u_log2 (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .m_i    (m_q),
    .side_i (lside_q),
    .f_o    (lf),
    .side_o (lside)
  );

  // |log2| * 4096 + gamma / 2, divided by the floored gamma
  logic [cgl_pkg::DEN_W-1:0] gamma_eff;
  logic [5:0]                int_part;
  logic signed [21:0]        l;
  logic [21:0]               mag;
  logic [cgl_pkg::NUM_W-1:0] num_q;
  cgl_pkg::div_side_t        dside_q;

  assign gamma_eff = ($signed(params_i.gamma) < cgl_pkg::GAMMA_FLOOR) ?
                     cgl_pkg::DEN_W'(cgl_pkg::GAMMA_FLOOR) : params_i.gamma[14:0];
  assign int_part  = 6'(lside.msb) - 6'd16;
  assign l         = $signed({int_part, lf});
  assign mag       = (l < 0) ? 22'(-l) : 22'(l);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q        <= {mag[20:0], 12'b0} + cgl_pkg::NUM_W'(gamma_eff >> 1);
      dside_q.neg  <= (l < 0);
      dside_q.zero <= lside.zero;
    end
  end

  logic [cgl_pkg::NUM_W-1:0] quo;
  cgl_pkg::div_side_t        dside;

  cgl_div u_div (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .num_i  (num_q),
    .den_i  (gamma_eff),
    .side_i (dside_q),
    .quo_o  (quo),
    .side_o (dside)
  );

  // split exponent: n = floor(e), fraction = low 16 bits
  logic signed [31:0]  e;
  logic signed [15:0]  n_s;
  logic [15:0]         ef_q;
  cgl_pkg::exp_side_t  eside_q;

  assign e   = dside.neg ? -$signed({1'b0, quo[cgl_pkg::QUO_W-1:0]})
                         :  $signed({1'b0, quo[cgl_pkg::QUO_W-1:0]});
  assign n_s = e[31:16];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ef_q         <= e[15:0];
      eside_q.n    <= e[31:16];
      eside_q.cap  <= (n_s >= 16'sd17);
      eside_q.zero <= dside.zero || (n_s < -16'sd40);
    end
  end

  logic [MW-1:0]      acc;
  cgl_pkg::exp_side_t eside;

  cgl_exp2 u_exp2 (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .f_i    (ef_q),
    .side_i (eside_q),
    .acc_o  (acc),
    .side_o (eside)
  );

  // scale by 2^n into Q16
  logic signed [15:0]         n_f;
  logic signed [15:0]         sh_s;
  logic [5:0]                 sh;
  logic [32:0]                big;
  logic [32:0]                rnd;
  logic [cgl_pkg::POW_W-1:0]  pow_d, pow_q;

  assign n_f  = $signed(eside.n);
  assign sh_s = 16'sd14 - n_f;
  assign sh   = sh_s[5:0];

  always_comb begin
    big   = '0;
    rnd   = '0;
    if (eside.zero) begin
      pow_d = '0;
    end else if (eside.cap) begin
      pow_d = '1;
    end else if (n_f >= 16'sd14) begin
      big   = 33'(acc) << 2'(n_f - 16'sd14);
      pow_d = (big > 33'h7FFF_FFFF) ? '1 : big[30:0];
    end else if (sh > 6'd32) begin
      pow_d = '0;
    end else begin
      rnd   = 33'(acc) + (33'd1 << (sh - 6'd1));
      pow_d = cgl_pkg::POW_W'(rnd >> sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) pow_q <= pow_d;
  end

  assign pow_o = pow_q;

endmodule

@@ design/cgl_mix.sv @@
// Luma-preserving saturation, contrast about 0.5, clamp and half encoding.
// Depends on cgl_pkg.
module cgl_mix (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [cgl_pkg::POW_W-1:0]   v_i   [3],
  input  logic [cgl_pkg::Q12_W-1:0]   sat_i,
  input  logic [cgl_pkg::Q12_W-1:0]   con_i,
  output logic [cgl_pkg::HALF_W-1:0]  half_o [3]
);

  localparam int PW = cgl_pkg::POW_W;
  localparam logic [15:0] Wt [3] = '{cgl_pkg::LUMA_WR, cgl_pkg::LUMA_WG, cgl_pkg::LUMA_WB};

  logic [46:0]               pr_q   [3];
  logic [PW-1:0]             v1_q   [3];
  logic [PW-1:0]             v2_q   [3];
  logic [31:0]               luma_q;
  logic [31:0]               luma3_q;
  logic signed [48:0]        sp_q   [3];
  logic signed [31:0]        x_q    [3];
  logic signed [47:0]        cp_q   [3];
  logic [cgl_pkg::COORD_W-1:0] c2_q [3];
  logic [cgl_pkg::HALF_W-1:0]  h_q  [3];

  logic [47:0]        lsum;
  logic signed [63:0] c1 [3];
  logic signed [63:0] x  [3];
  logic signed [63:0] c2 [3];
  logic signed [32:0] d  [3];

  assign lsum = 48'(pr_q[0]) + 48'(pr_q[1]) + 48'(pr_q[2]) + 48'd32768;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      d[ch]  = $signed({2'b0, v2_q[ch]}) - $signed({1'b0, luma_q});
      c1[ch] = $signed(64'(luma3_q)) + cgl_pkg::shr_round12(64'(sp_q[ch]));
      x[ch]  = c1[ch] - 64'sd32768;
      // beyond +-2^30 the contrast step clamps the same way for any nonzero gain
      if (x[ch] > 64'sd1073741824)       x[ch] = 64'sd1073741824;
      else if (x[ch] < -64'sd1073741824) x[ch] = -64'sd1073741824;
      c2[ch] = cgl_pkg::shr_round12(64'(cp_q[ch])) + 64'sd32768;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      luma_q  <= lsum[47:16];
      luma3_q <= luma_q;
      for (int ch = 0; ch < 3; ch++) begin
        pr_q[ch] <= v_i[ch] * Wt[ch];
        v1_q[ch] <= v_i[ch];
        v2_q[ch] <= v1_q[ch];
        sp_q[ch] <= d[ch] * $signed(sat_i);
        x_q[ch]  <= 32'(x[ch]);
        cp_q[ch] <= x_q[ch] * $signed(con_i);
        if (c2[ch] < 0)                            c2_q[ch] <= '0;
        else if (c2[ch] > 64'(cgl_pkg::Q16_ONE))   c2_q[ch] <= cgl_pkg::COORD_W'(cgl_pkg::Q16_ONE);
        else                                       c2_q[ch] <= c2[ch][16:0];
        h_q[ch] <= cgl_pkg::to_half(c2_q[ch]);
      end
    end
  end

  assign half_o = h_q;

endmodule
